// ----- sv/spl_pkg.sv -----
// shared types, constants and segment tables of the sensor linearizer
package spl_pkg;

    // payload widths
    localparam int ADC_W   = 12;
    localparam int MODE_W  = 3;
    localparam int CHAN_W  = 2;
    localparam int QTY_W   = 40;
    localparam int RNG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // internal widths
    localparam int ADC_MUL_W = 21;
    localparam int V_W       = 9;
    localparam int PROD_W    = 17;
    localparam int X_W       = 10;
    localparam int DX_W      = 9;
    localparam int Y_W       = 12;
    localparam int DY_W      = 13;
    localparam int OFF_W     = 11;
    localparam int P1_W      = 22;
    localparam int P2_W      = 24;
    localparam int NUM_W     = 25;
    localparam int ABS_W     = 24;
    localparam int K_W       = 18;
    localparam int DEN_W     = 27;
    localparam int MAG_W     = 40;

    // converter scaling: hundredths of a volt = code*330/4096
    localparam int ADC_SCALE = 330;
    localparam int ADC_SHIFT = 12;

    // segment index by reciprocal: v/10 = (v*205)>>11, v/5 = (v*205)>>10 for v < 330
    localparam int DIV_RECIP    = 205;
    localparam int DIV10_SHIFT  = 11;
    localparam int DIV5_SHIFT   = 10;

    // table sizes and segment limits
    localparam int PRESSURE_TABLE_ENTRIES = 34;
    localparam int TEMP_TABLE_ENTRIES     = 67;
    localparam int PTAB_SIZE = 34;
    localparam int TTAB_SIZE = 67;
    localparam int P_COUNT0 = (PRESSURE_TABLE_ENTRIES < PTAB_SIZE) ?
                              PRESSURE_TABLE_ENTRIES : PTAB_SIZE;
    localparam int T_COUNT0 = (TEMP_TABLE_ENTRIES < TTAB_SIZE) ?
                              TEMP_TABLE_ENTRIES : TTAB_SIZE;
    localparam int P_COUNT  = (P_COUNT0 < 2) ? 2 : P_COUNT0;
    localparam int T_COUNT  = (T_COUNT0 < 2) ? 2 : T_COUNT0;
    localparam int P_LIM    = P_COUNT - 2;
    localparam int T_LIM    = T_COUNT - 2;
    localparam int P_IDX_W  = $clog2(PTAB_SIZE);
    localparam int T_IDX_W  = $clog2(TTAB_SIZE);
    localparam int IDX_W    = (T_IDX_W > P_IDX_W) ? T_IDX_W : P_IDX_W;

    // y scale times range divisor
    localparam int K_PRESS_PR  = 160000;
    localparam int K_PRESS_LVL = 100000;
    localparam int K_LVL_PR    = 1600;
    localparam int K_LVL_LVL   = 1000;
    localparam int K_NTC       = 10;

    localparam int OUTLET_RESET   = 1600;
    localparam int ENTRANCE_RESET = 1600;
    localparam int TANK_RESET     = 1000;

    localparam logic [CHAN_W-1:0] CH_OUTLET   = 2'd0;
    localparam logic [CHAN_W-1:0] CH_ENTRANCE = 2'd1;

    localparam logic signed [QTY_W-1:0] QTY_MAX = {1'b0, {(QTY_W-1){1'b1}}};
    localparam logic signed [QTY_W-1:0] QTY_MIN = {1'b1, {(QTY_W-1){1'b0}}};

    typedef enum logic [MODE_W-1:0] {
        MODE_PM_PRESS = 3'd0,
        MODE_PT_PRESS = 3'd1,
        MODE_PM_LEVEL = 3'd2,
        MODE_PT_LEVEL = 3'd3,
        MODE_NTC      = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTLET   = 2'd0,
        CFG_ENTRANCE = 2'd1,
        CFG_TANK     = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        int x;
        int y;
    } t_seg_pt;

    localparam t_seg_pt PM_PRESS [PTAB_SIZE] = '{
        '{0, -10}, '{10, 1}, '{20, 12}, '{28, 19}, '{40, 29}, '{47, 37}, '{60, 50},
        '{75, 64}, '{85, 74}, '{94, 83}, '{100, 90}, '{110, 100}, '{123, 110},
        '{130, 118}, '{142, 128}, '{152, 137}, '{161, 146}, '{170, 155},
        '{180, 163}, '{200, 180}, '{205, 185}, '{210, 188}, '{220, 195},
        '{230, 205}, '{240, 215}, '{250, 225}, '{260, 235}, '{270, 245},
        '{280, 255}, '{290, 265}, '{300, 275}, '{310, 285}, '{320, 295},
        '{330, 305}};

    localparam t_seg_pt PT_PRESS [PTAB_SIZE] = '{
        '{0, -44}, '{10, -35}, '{19, -26}, '{29, -17}, '{40, -8}, '{50, 1},
        '{60, 10}, '{70, 22}, '{80, 32}, '{90, 40}, '{100, 53}, '{110, 62},
        '{120, 70}, '{130, 75}, '{140, 84}, '{150, 95}, '{160, 105}, '{170, 110},
        '{180, 120}, '{190, 132}, '{200, 140}, '{210, 147}, '{220, 157},
        '{230, 166}, '{240, 175}, '{250, 184}, '{260, 193}, '{270, 202},
        '{280, 211}, '{290, 220}, '{300, 229}, '{310, 238}, '{320, 247},
        '{330, 256}};

    localparam t_seg_pt PM_LEVEL [PTAB_SIZE] = '{
        '{0, 0}, '{9, 20}, '{20, 70}, '{30, 120}, '{40, 178}, '{50, 240},
        '{60, 300}, '{70, 360}, '{80, 410}, '{90, 465}, '{100, 520}, '{110, 580},
        '{120, 640}, '{130, 698}, '{140, 750}, '{150, 806}, '{160, 867},
        '{170, 930}, '{180, 985}, '{190, 1000}, '{200, 1000}, '{210, 1000},
        '{220, 1000}, '{230, 1000}, '{240, 1000}, '{250, 1000}, '{260, 1000},
        '{270, 1000}, '{280, 1000}, '{290, 1000}, '{300, 1000}, '{310, 1000},
        '{320, 1000}, '{330, 1000}};

    localparam t_seg_pt PT_LEVEL [PTAB_SIZE] = '{
        '{0, 0}, '{9, 0}, '{20, 0}, '{30, 0}, '{40, 0}, '{50, 50}, '{60, 60},
        '{70, 120}, '{80, 178}, '{90, 240}, '{100, 305}, '{110, 360}, '{120, 410},
        '{130, 460}, '{140, 500}, '{150, 560}, '{160, 615}, '{170, 670},
        '{180, 725}, '{190, 757}, '{200, 810}, '{210, 870}, '{220, 927},
        '{230, 990}, '{240, 1000}, '{250, 1000}, '{260, 1000}, '{270, 1000},
        '{280, 1000}, '{290, 1000}, '{300, 1000}, '{310, 1000}, '{320, 1000},
        '{330, 1000}};

    localparam t_seg_pt NTC_TEMP [TTAB_SIZE] = '{
        '{0, 1500}, '{5, 1500}, '{10, 1450}, '{15, 1375}, '{20, 1300}, '{25, 1225},
        '{30, 1150}, '{38, 1030}, '{40, 1000}, '{46, 950}, '{51, 900}, '{58, 850},
        '{60, 830}, '{65, 800}, '{72, 760}, '{75, 745}, '{78, 730}, '{82, 710},
        '{89, 680}, '{93, 660}, '{101, 630}, '{106, 610}, '{111, 590}, '{115, 575},
        '{119, 560}, '{125, 540}, '{130, 520}, '{135, 503}, '{139, 490},
        '{145, 470}, '{148, 460}, '{154, 440}, '{162, 420}, '{168, 400},
        '{170, 390}, '{178, 370}, '{180, 365}, '{184, 350}, '{191, 330},
        '{195, 320}, '{200, 310}, '{208, 280}, '{210, 270}, '{214, 250},
        '{220, 239}, '{225, 230}, '{230, 200}, '{238, 170}, '{240, 160},
        '{245, 150}, '{253, 120}, '{258, 100}, '{263, 80}, '{265, 72}, '{272, 50},
        '{278, 30}, '{280, 23}, '{283, 10}, '{290, -40}, '{294, -60}, '{301, -80},
        '{304, -100}, '{306, -120}, '{315, -210}, '{320, -260}, '{325, -310},
        '{330, -360}};

endpackage

// ----- sv/spl_if.sv -----
// valid/ready channel interfaces of the sensor linearizer

interface spl_in_if;
    logic                          valid;
    logic                          ready;
    logic [spl_pkg::ADC_W-1:0]     adc_code;
    logic [spl_pkg::MODE_W-1:0]    mode;
    logic [spl_pkg::CHAN_W-1:0]    channel;

    modport source (output valid, output adc_code, output mode, output channel,
                    input ready);
    modport sink   (input valid, input adc_code, input mode, input channel,
                    output ready);
endinterface

interface spl_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [spl_pkg::QTY_W-1:0] quantity;
    logic                             saturated;

    modport source (output valid, output quantity, output saturated, input ready);
    modport sink   (input valid, input quantity, input saturated, output ready);
endinterface

interface spl_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [spl_pkg::CFG_IDX_W-1:0]  index;
    logic [spl_pkg::RNG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/sensor_piecewise_linearizer_core.sv -----
// sensor linearizer top level: segment lookup, interpolation, range scaling, rounding divide
// a request passes stages 1 to 7, the divider and the output register on its way to o_out
// throughput: one request per cycle; the whole pipeline, 40 divider stages included,
//   advances together and holds while the output register is full and not taken
// the rounding divide produces one quotient bit per stage, which sets the depth
// reset (synchronous, active low) clears all valid bits and loads the range registers
module sensor_piecewise_linearizer_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spl_cfg_if.sink   i_cfg,
    spl_in_if.sink    i_in,
    spl_out_if.source o_out
);
    import spl_pkg::*;

    localparam int NW    = MAG_W + FRAC_BITS + 2;
    localparam int TOP_W = NW - QTY_W;
    localparam int D_W   = DEN_W + 1;
    localparam int CMP_W = (TOP_W > D_W) ? TOP_W : D_W;

    // range registers
    logic [RNG_W-1:0] r_outlet;
    logic [RNG_W-1:0] r_entrance;
    logic [RNG_W-1:0] r_tank;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outlet   <= RNG_W'(OUTLET_RESET);
            r_entrance <= RNG_W'(ENTRANCE_RESET);
            r_tank     <= RNG_W'(TANK_RESET);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_OUTLET:   r_outlet   <= i_cfg.data;
                CFG_ENTRANCE: r_entrance <= i_cfg.data;
                CFG_TANK:     r_tank     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    logic en;
    logic r_out_v;

    assign en         = !r_out_v || o_out.ready;
    assign i_in.ready = en;

    // stage 1: volts, range and divisor constant
    logic [V_W-1:0]    n_s1_volt;
    logic [RNG_W-1:0]  n_s1_rng;
    logic [K_W-1:0]    n_s1_k;
    logic              n_s1_ok;
    logic              n_s1_press;

    logic              r_s1_v;
    logic [V_W-1:0]    r_s1_volt;
    logic [MODE_W-1:0] r_s1_mode;
    logic [RNG_W-1:0]  r_s1_rng;
    logic [K_W-1:0]    r_s1_k;
    logic              r_s1_ok;

    always_comb begin
        n_s1_volt  = V_W'((ADC_MUL_W'(i_in.adc_code) * ADC_MUL_W'(ADC_SCALE)) >> ADC_SHIFT);
        n_s1_ok    = i_in.mode <= MODE_NTC;
        n_s1_press = i_in.mode <= MODE_PT_PRESS;
        n_s1_rng   = RNG_W'(1);
        n_s1_k     = K_W'(K_NTC);
        if (i_in.mode < MODE_NTC) begin
            if (i_in.channel == CH_OUTLET) begin
                n_s1_rng = r_outlet;
                n_s1_k   = n_s1_press ? K_W'(K_PRESS_PR) : K_W'(K_LVL_PR);
            end else if (i_in.channel == CH_ENTRANCE && n_s1_press) begin
                n_s1_rng = r_entrance;
                n_s1_k   = K_W'(K_PRESS_PR);
            end else begin
                n_s1_rng = r_tank;
                n_s1_k   = n_s1_press ? K_W'(K_PRESS_LVL) : K_W'(K_LVL_LVL);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_volt <= n_s1_volt;
            r_s1_mode <= i_in.mode;
            r_s1_rng  <= n_s1_rng;
            r_s1_k    <= n_s1_k;
            r_s1_ok   <= n_s1_ok;
        end
    end

    // stage 2: segment index
    logic [PROD_W-1:0]  n_s2_prod;
    logic [T_IDX_W-1:0] n_s2_it;
    logic [P_IDX_W-1:0] n_s2_ip;
    logic [IDX_W-1:0]   n_s2_idx;

    logic              r_s2_v;
    logic [IDX_W-1:0]  r_s2_idx;
    logic [V_W-1:0]    r_s2_volt;
    logic [MODE_W-1:0] r_s2_mode;
    logic [RNG_W-1:0]  r_s2_rng;
    logic [K_W-1:0]    r_s2_k;
    logic              r_s2_ok;

    always_comb begin
        n_s2_prod = PROD_W'(r_s1_volt) * PROD_W'(DIV_RECIP);
        n_s2_it   = T_IDX_W'(n_s2_prod >> DIV5_SHIFT);
        n_s2_ip   = P_IDX_W'(n_s2_prod >> DIV10_SHIFT);
        if (n_s2_it > T_IDX_W'(T_LIM)) begin
            n_s2_it = T_IDX_W'(T_LIM);
        end
        if (n_s2_ip > P_IDX_W'(P_LIM)) begin
            n_s2_ip = P_IDX_W'(P_LIM);
        end
        n_s2_idx = (r_s1_mode == MODE_NTC) ? IDX_W'(n_s2_it) : IDX_W'(n_s2_ip);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_idx  <= n_s2_idx;
            r_s2_volt <= r_s1_volt;
            r_s2_mode <= r_s1_mode;
            r_s2_rng  <= r_s1_rng;
            r_s2_k    <= r_s1_k;
            r_s2_ok   <= r_s1_ok;
        end
    end

    // stage 3: table lookup and segment deltas
    t_seg_pt                   n_s3_pa;
    t_seg_pt                   n_s3_pb;
    logic [P_IDX_W-1:0]        n_s3_ip0;
    logic [P_IDX_W-1:0]        n_s3_ip1;
    logic [T_IDX_W-1:0]        n_s3_it0;
    logic [T_IDX_W-1:0]        n_s3_it1;
    logic signed [X_W-1:0]     n_s3_x1;
    logic signed [X_W-1:0]     n_s3_x2;
    logic signed [X_W-1:0]     n_s3_dxs;
    logic                      n_s3_flat;

    logic                      r_s3_v;
    logic signed [Y_W-1:0]     r_s3_y1;
    logic signed [DY_W-1:0]    r_s3_dy;
    logic signed [OFF_W-1:0]   r_s3_off;
    logic [DX_W-1:0]           r_s3_dx;
    logic                      r_s3_flat;
    logic [RNG_W-1:0]          r_s3_rng;
    logic [K_W-1:0]            r_s3_k;
    logic                      r_s3_ok;

    always_comb begin
        n_s3_ip0 = r_s2_idx[P_IDX_W-1:0];
        n_s3_ip1 = n_s3_ip0 + P_IDX_W'(1);
        n_s3_it0 = r_s2_idx[T_IDX_W-1:0];
        n_s3_it1 = n_s3_it0 + T_IDX_W'(1);
        unique case (r_s2_mode)
            MODE_PM_PRESS: begin
                n_s3_pa = PM_PRESS[n_s3_ip0];
                n_s3_pb = PM_PRESS[n_s3_ip1];
            end
            MODE_PT_PRESS: begin
                n_s3_pa = PT_PRESS[n_s3_ip0];
                n_s3_pb = PT_PRESS[n_s3_ip1];
            end
            MODE_PM_LEVEL: begin
                n_s3_pa = PM_LEVEL[n_s3_ip0];
                n_s3_pb = PM_LEVEL[n_s3_ip1];
            end
            MODE_PT_LEVEL: begin
                n_s3_pa = PT_LEVEL[n_s3_ip0];
                n_s3_pb = PT_LEVEL[n_s3_ip1];
            end
            MODE_NTC: begin
                n_s3_pa = NTC_TEMP[n_s3_it0];
                n_s3_pb = NTC_TEMP[n_s3_it1];
            end
            default: begin
                n_s3_pa = '0;
                n_s3_pb = '0;
            end
        endcase
        n_s3_x1   = X_W'(n_s3_pa.x);
        n_s3_x2   = X_W'(n_s3_pb.x);
        n_s3_dxs  = n_s3_x2 - n_s3_x1;
        // degenerate segment: hold y1
        n_s3_flat = n_s3_dxs <= 0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_y1   <= Y_W'(n_s3_pa.y);
            r_s3_dy   <= DY_W'(n_s3_pb.y) - DY_W'(n_s3_pa.y);
            r_s3_off  <= OFF_W'($signed({2'b00, r_s2_volt})) - OFF_W'(n_s3_x1);
            r_s3_dx   <= n_s3_flat ? DX_W'(1) : DX_W'(n_s3_dxs);
            r_s3_flat <= n_s3_flat;
            r_s3_rng  <= r_s2_rng;
            r_s3_k    <= r_s2_k;
            r_s3_ok   <= r_s2_ok;
        end
    end

    // stage 4: partial products of the numerator
    logic                    r_s4_v;
    logic signed [P1_W-1:0]  r_s4_p1;
    logic signed [P2_W-1:0]  r_s4_p2;
    logic [DX_W-1:0]         r_s4_dx;
    logic [RNG_W-1:0]        r_s4_rng;
    logic [K_W-1:0]          r_s4_k;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_p1  <= r_s3_ok ? P1_W'(r_s3_y1) * P1_W'($signed({1'b0, r_s3_dx})) : '0;
            r_s4_p2  <= (r_s3_ok && !r_s3_flat) ? P2_W'(r_s3_off) * P2_W'(r_s3_dy) : '0;
            r_s4_dx  <= r_s3_dx;
            r_s4_rng <= r_s3_rng;
            r_s4_k   <= r_s3_k;
        end
    end

    // stage 5: numerator sign and magnitude, denominator
    logic signed [NUM_W-1:0] n_s5_num;
    logic                    n_s5_neg;

    logic                    r_s5_v;
    logic [ABS_W-1:0]        r_s5_abs;
    logic                    r_s5_neg;
    logic [DEN_W-1:0]        r_s5_den;
    logic [RNG_W-1:0]        r_s5_rng;

    always_comb begin
        n_s5_num = NUM_W'(r_s4_p1) + NUM_W'(r_s4_p2);
        n_s5_neg = n_s5_num[NUM_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_abs <= ABS_W'(n_s5_neg ? -n_s5_num : n_s5_num);
            r_s5_neg <= n_s5_neg;
            r_s5_den <= DEN_W'(r_s4_dx) * DEN_W'(r_s4_k);
            r_s5_rng <= r_s4_rng;
        end
    end

    // stage 6: range scaling
    logic              r_s6_v;
    logic [MAG_W-1:0]  r_s6_mag;
    logic              r_s6_neg;
    logic [DEN_W-1:0]  r_s6_den;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_mag <= MAG_W'(r_s5_abs) * MAG_W'(r_s5_rng);
            r_s6_neg <= r_s5_neg;
            r_s6_den <= r_s5_den;
        end
    end

    // stage 7: dividend with half divisor added for round half up
    logic              r_s7_v;
    logic [NW-1:0]     r_s7_n;
    logic [D_W-1:0]    r_s7_d;
    logic              r_s7_neg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_n   <= (NW'(r_s6_mag) << (FRAC_BITS + 1)) + NW'(r_s6_den);
            r_s7_d   <= {r_s6_den, 1'b0};
            r_s7_neg <= r_s6_neg;
        end
    end

    // restoring divider, one quotient bit per stage
    logic              r_dv_v   [0:QTY_W];
    logic [D_W-1:0]    r_dv_rem [0:QTY_W];
    logic [QTY_W-1:0]  r_dv_nq  [0:QTY_W];
    logic [D_W-1:0]    r_dv_d   [0:QTY_W];
    logic              r_dv_neg [0:QTY_W];
    logic              r_dv_ovf [0:QTY_W];

    logic [TOP_W-1:0]  n_dv_top;

    assign n_dv_top = r_s7_n[NW-1:QTY_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_rem[0] <= D_W'(n_dv_top);
            r_dv_nq[0]  <= r_s7_n[QTY_W-1:0];
            r_dv_d[0]   <= r_s7_d;
            r_dv_neg[0] <= r_s7_neg;
            // quotient would need more than the field width
            r_dv_ovf[0] <= CMP_W'(n_dv_top) >= CMP_W'(r_s7_d);
        end
    end

    for (genvar j = 1; j <= QTY_W; j++) begin : g_div
        logic [D_W:0] n_t;
        logic         n_ge;

        always_comb begin
            n_t  = {r_dv_rem[j-1], r_dv_nq[j-1][QTY_W-1]};
            n_ge = n_t >= {1'b0, r_dv_d[j-1]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (en) begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem[j] <= n_ge ? D_W'(n_t - {1'b0, r_dv_d[j-1]}) : D_W'(n_t);
                r_dv_nq[j]  <= {r_dv_nq[j-1][QTY_W-2:0], n_ge};
                r_dv_d[j]   <= r_dv_d[j-1];
                r_dv_neg[j] <= r_dv_neg[j-1];
                r_dv_ovf[j] <= r_dv_ovf[j-1];
            end
        end
    end

    // control valid chain up to the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_s4_v    <= 1'b0;
            r_s5_v    <= 1'b0;
            r_s6_v    <= 1'b0;
            r_s7_v    <= 1'b0;
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_s1_v    <= i_in.valid;
            r_s2_v    <= r_s1_v;
            r_s3_v    <= r_s2_v;
            r_s4_v    <= r_s3_v;
            r_s5_v    <= r_s4_v;
            r_s6_v    <= r_s5_v;
            r_s7_v    <= r_s6_v;
            r_dv_v[0] <= r_s7_v;
        end
    end

    // sign, saturation and output register
    logic [QTY_W-1:0]        n_q;
    logic signed [QTY_W-1:0] n_qty;
    logic                    n_sat;

    logic signed [QTY_W-1:0] r_out_qty;
    logic                    r_out_sat;

    always_comb begin
        n_q   = r_dv_nq[QTY_W];
        n_sat = 1'b0;
        if (r_dv_ovf[QTY_W]) begin
            n_sat = 1'b1;
            n_qty = r_dv_neg[QTY_W] ? QTY_MIN : QTY_MAX;
        end else if (!r_dv_neg[QTY_W]) begin
            n_sat = n_q[QTY_W-1];
            n_qty = n_sat ? QTY_MAX : $signed(n_q);
        end else begin
            // magnitude of exactly 2^39 still fits on the negative side
            n_sat = n_q[QTY_W-1] && |n_q[QTY_W-2:0];
            n_qty = n_sat ? QTY_MIN : $signed(-n_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv_v[QTY_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_qty <= n_qty;
            r_out_sat <= n_sat;
        end
    end

    assign o_out.valid     = r_out_v;
    assign o_out.quantity  = r_out_qty;
    assign o_out.saturated = r_out_sat;

endmodule

// ----- sv/spl_checker.sv -----
// port-level checks of the sensor linearizer and their bind
module spl_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [spl_pkg::QTY_W-1:0]    i_out_quantity,
    input logic                                i_out_saturated
);
    import spl_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_quantity) && $stable(i_out_saturated))
        else $error("result changed while stalled");

    // an empty output register never blocks requests
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request blocked with empty output");

    // a clamped result sits on one of the field limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_saturated |->
            i_out_quantity == QTY_MAX || i_out_quantity == QTY_MIN)
        else $error("saturated result off the limits");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result present after reset");

endmodule

bind sensor_piecewise_linearizer_core spl_checker u_spl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_quantity  (o_out.quantity),
    .i_out_saturated (o_out.saturated)
);
